>>> rtl/imuhd_pkg.sv
// Package: shared widths, constants, CORDIC arc table and handshake structs.
`default_nettype none

package imuhd_pkg;

  // Field widths
  localparam int BytesW = 48;
  localparam int AccW   = 16;
  localparam int FieldW = 23;
  localparam int HeadW  = 16;
  localparam int ScaleW = 7;

  // Magnetometer byte layouts
  localparam logic MagFmtLeXyz = 1'b0;
  localparam logic MagFmtBeXzy = 1'b1;

  // Scale factors to 0.01 uT per layout
  localparam logic [ScaleW-1:0] MagScaleLe = 7'd6;
  localparam logic [ScaleW-1:0] MagScaleBe = 7'd92;

  // CORDIC datapath: vector is field * 2^16 plus growth headroom
  localparam int VecFracW = 16;
  localparam int VecW     = 41;
  localparam int AngW     = 26;
  localparam int TabLen   = 24;
  localparam int TabIdxW  = 5;
  localparam int TabW     = 21;

  // Angles in 1/256 of 0.01 degree; FullTurnCd is in 0.01 degree
  localparam logic [AngW-1:0] HalfTurnAng  = 26'd4608000;
  localparam logic [AngW-1:0] AngRoundBias = 26'd128;
  localparam int              AngFracW     = 8;
  localparam logic [AngW-1:0] FullTurnCd   = 26'd36000;

  // Arc-tangent table, atan(2^-i) in angle units
  function automatic logic [TabW-1:0] atan_tab(input logic [TabIdxW-1:0] idx);
    logic [TabW-1:0] v;
    begin
      case (idx)
        5'd0:    v = 21'd1152000;
        5'd1:    v = 21'd680065;
        5'd2:    v = 21'd359328;
        5'd3:    v = 21'd182400;
        5'd4:    v = 21'd91554;
        5'd5:    v = 21'd45822;
        5'd6:    v = 21'd22916;
        5'd7:    v = 21'd11459;
        5'd8:    v = 21'd5730;
        5'd9:    v = 21'd2865;
        5'd10:   v = 21'd1432;
        5'd11:   v = 21'd716;
        5'd12:   v = 21'd358;
        5'd13:   v = 21'd179;
        5'd14:   v = 21'd90;
        5'd15:   v = 21'd45;
        5'd16:   v = 21'd22;
        5'd17:   v = 21'd11;
        5'd18:   v = 21'd6;
        5'd19:   v = 21'd3;
        5'd20:   v = 21'd1;
        5'd21:   v = 21'd1;
        default: v = 21'd0;
      endcase
      return v;
    end
  endfunction

  // Request from the sequencer into the heading unit
  typedef struct packed {
    logic start;
    logic ack;
  } cordic_req_t;

  // Status from the heading unit
  typedef struct packed {
    logic             valid;
    logic [HeadW-1:0] heading;
  } cordic_rsp_t;

endpackage

`default_nettype wire

>>> rtl/imuhd_if.sv
// Interfaces: sample input, result output and configuration write channels.
`default_nettype none

interface imuhd_in_if;
  logic                            valid;
  logic                            ready;
  logic [imuhd_pkg::BytesW-1:0]    acc_bytes;
  logic                            acc_read_ok;
  logic [imuhd_pkg::BytesW-1:0]    mag_bytes;
  logic                            mag_read_ok;

  modport source (output valid, acc_bytes, acc_read_ok, mag_bytes, mag_read_ok,
                  input ready);
  modport sink   (input valid, acc_bytes, acc_read_ok, mag_bytes, mag_read_ok,
                  output ready);
endinterface

interface imuhd_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [imuhd_pkg::AccW-1:0]   accel_x;
  logic signed [imuhd_pkg::AccW-1:0]   accel_y;
  logic signed [imuhd_pkg::AccW-1:0]   accel_z;
  logic signed [imuhd_pkg::FieldW-1:0] field_x;
  logic signed [imuhd_pkg::FieldW-1:0] field_y;
  logic signed [imuhd_pkg::FieldW-1:0] field_z;
  logic [imuhd_pkg::HeadW-1:0]         heading_centideg;
  logic                                acc_valid;
  logic                                mag_valid;

  modport source (output valid, accel_x, accel_y, accel_z, field_x, field_y, field_z,
                  heading_centideg, acc_valid, mag_valid, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, field_x, field_y, field_z,
                  heading_centideg, acc_valid, mag_valid, output ready);
endinterface

interface imuhd_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

>>> rtl/imuhd_cordic.sv
// Iterative vectoring CORDIC: heading of (fx, fy) in 0.01 degree, one step per cycle.
`default_nettype none

module imuhd_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire imuhd_pkg::cordic_req_t              req_i,
  input  wire logic signed [imuhd_pkg::FieldW-1:0] fx_i,
  input  wire logic signed [imuhd_pkg::FieldW-1:0] fy_i,
  output imuhd_pkg::cordic_rsp_t                   rsp_o
);

  localparam int VecW  = imuhd_pkg::VecW;
  localparam int AngW  = imuhd_pkg::AngW;
  localparam int ExtW  = VecW - imuhd_pkg::FieldW - imuhd_pkg::VecFracW;
  localparam int Steps = (CORDIC_STEPS > imuhd_pkg::TabLen) ? imuhd_pkg::TabLen
                                                              : CORDIC_STEPS;
  localparam int CntW  = (Steps > 1) ? $clog2(Steps) : 1;
  localparam logic [CntW-1:0] LastStep = CntW'(Steps - 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StIter = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic signed [VecW-1:0]      x_q, x_d, y_q, y_d;
  logic signed [AngW-1:0]      z_q, z_d;
  logic [imuhd_pkg::HeadW-1:0] head_q, head_d;

  logic signed [VecW-1:0] x_init, y_init, xs, ys;
  logic signed [AngW-1:0] arc, z_rnd, h_raw, h_wrap;
  logic                   y_pos;

  // Scale the field into the vector format, sign-extended into the headroom
  assign x_init = {{ExtW{fx_i[imuhd_pkg::FieldW-1]}}, fx_i, {imuhd_pkg::VecFracW{1'b0}}};
  assign y_init = {{ExtW{fy_i[imuhd_pkg::FieldW-1]}}, fy_i, {imuhd_pkg::VecFracW{1'b0}}};

  // Shared shifter and table lookup for the current step
  assign xs    = x_q >>> cnt_q;
  assign ys    = y_q >>> cnt_q;
  assign y_pos = !y_q[VecW-1] && (y_q != '0);
  assign arc   = AngW'(imuhd_pkg::atan_tab(imuhd_pkg::TabIdxW'(cnt_q)));

  // Round to 0.01 degree and wrap into one turn
  always_comb begin
    z_rnd = z_q + imuhd_pkg::AngRoundBias;
    h_raw = z_rnd >>> imuhd_pkg::AngFracW;
    if (h_raw[AngW-1]) begin
      h_wrap = h_raw + imuhd_pkg::FullTurnCd;
    end else if (h_raw >= imuhd_pkg::FullTurnCd) begin
      h_wrap = h_raw - imuhd_pkg::FullTurnCd;
    end else begin
      h_wrap = h_raw;
    end
  end

  // Sequence load, steps, rounding and hand-off
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    head_d  = head_q;
    unique case (state_q)
      StIdle: begin
        if (req_i.start) begin
          cnt_d = '0;
          if (fx_i == '0 && fy_i == '0) begin
            head_d  = '0;
            state_d = StDone;
          end else if (fx_i[imuhd_pkg::FieldW-1]) begin
            x_d     = -x_init;
            y_d     = -y_init;
            z_d     = imuhd_pkg::HalfTurnAng;
            state_d = StIter;
          end else begin
            x_d     = x_init;
            y_d     = y_init;
            z_d     = '0;
            state_d = StIter;
          end
        end
      end
      StIter: begin
        if (y_pos) begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + arc;
        end else begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - arc;
        end
        if (cnt_q == LastStep) begin
          state_d = StFin;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StFin: begin
        head_d  = imuhd_pkg::HeadW'(h_wrap);
        state_d = StDone;
      end
      StDone: begin
        if (req_i.ack) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    head_q <= head_d;
  end

  assign rsp_o.valid   = (state_q == StDone);
  assign rsp_o.heading = head_q;

endmodule

`default_nettype wire

>>> rtl/imu_sample_scale_and_heading_unit.sv
// Top level: sample unpack and scaling, held sensor values, heading sequencer, output register.
//
//  channel | dir | handshake     | payload
//  smp_i   | in  | valid/ready   | acc_bytes, acc_read_ok, mag_bytes, mag_read_ok
//  res_o   | out | valid/ready   | accel_x/y/z, field_x/y/z, heading_centideg, flags
//  cfg_i   | in  | valid/ready   | data = mag_format (always ready)
//
// From accept to result a transaction passes the start register, the CORDIC unit, which
// retires one rotation step per cycle, and the output register; a zero field skips the steps.
// The next sample is accepted once the result has moved into the output register, so a
// waiting result does not block it; a stalled output holds the heading unit in its done state.
// Reset clears the held values to zero, mag_format to 0 and the result valid flag, not the read flags.
`default_nettype none

module imu_sample_scale_and_heading_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  imuhd_in_if.sink    smp_i,
  imuhd_out_if.source res_o,
  imuhd_cfg_if.sink   cfg_i
);

  localparam int AccW   = imuhd_pkg::AccW;
  localparam int FieldW = imuhd_pkg::FieldW;

  logic                     mag_fmt_q;
  logic                     busy_q, start_q, out_valid_q;
  logic                     acc_ok_q, mag_ok_q;
  logic signed [AccW-1:0]   acc_q   [3];
  logic signed [FieldW-1:0] field_q [3];
  logic signed [FieldW-1:0] field_d [3];
  logic signed [AccW-1:0]   mag_w   [3];
  logic signed [FieldW-1:0] scale;
  logic                     accept;

  imuhd_pkg::cordic_req_t req;
  imuhd_pkg::cordic_rsp_t rsp;

  // Output register contents
  logic signed [AccW-1:0]      o_acc_q   [3];
  logic signed [FieldW-1:0]    o_field_q [3];
  logic [imuhd_pkg::HeadW-1:0] o_head_q;
  logic                        o_acc_ok_q, o_mag_ok_q;

  assign smp_i.ready = !busy_q;
  assign accept      = smp_i.valid && !busy_q;
  assign cfg_i.ready = 1'b1;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_fmt_q <= imuhd_pkg::MagFmtLeXyz;
    end else if (cfg_i.valid) begin
      mag_fmt_q <= cfg_i.data;
    end
  end

  // Decode magnetometer words by layout
  always_comb begin
    if (mag_fmt_q == imuhd_pkg::MagFmtBeXzy) begin
      mag_w[0] = {smp_i.mag_bytes[7:0],   smp_i.mag_bytes[15:8]};
      mag_w[2] = {smp_i.mag_bytes[23:16], smp_i.mag_bytes[31:24]};
      mag_w[1] = {smp_i.mag_bytes[39:32], smp_i.mag_bytes[47:40]};
      scale    = FieldW'(imuhd_pkg::MagScaleBe);
    end else begin
      mag_w[0] = smp_i.mag_bytes[15:0];
      mag_w[1] = smp_i.mag_bytes[31:16];
      mag_w[2] = smp_i.mag_bytes[47:32];
      scale    = FieldW'(imuhd_pkg::MagScaleLe);
    end
  end

  // Scale to 0.01 uT
  for (genvar k = 0; k < 3; k++) begin : g_scale
    logic signed [FieldW-1:0] w_ext;
    assign w_ext      = FieldW'(mag_w[k]);
    assign field_d[k] = w_ext * scale;
  end

  // Update held values on a good read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        acc_q[k]   <= '0;
        field_q[k] <= '0;
      end
    end else if (accept) begin
      if (smp_i.acc_read_ok) begin
        acc_q[0] <= smp_i.acc_bytes[15:0];
        acc_q[1] <= smp_i.acc_bytes[31:16];
        acc_q[2] <= smp_i.acc_bytes[47:32];
      end
      if (smp_i.mag_read_ok) begin
        for (int k = 0; k < 3; k++) begin
          field_q[k] <= field_d[k];
        end
      end
    end
  end

  // Capture read flags with the transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      acc_ok_q <= smp_i.acc_read_ok;
      mag_ok_q <= smp_i.mag_read_ok;
    end
  end

  // Sequencer: start heading unit, move its result into the output register
  assign req.start = start_q;
  assign req.ack   = rsp.valid && (!out_valid_q || res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      start_q <= accept;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (req.ack) begin
        busy_q <= 1'b0;
      end
      if (req.ack) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load output register
  always_ff @(posedge clk_i) begin
    if (req.ack) begin
      for (int k = 0; k < 3; k++) begin
        o_acc_q[k]   <= acc_q[k];
        o_field_q[k] <= field_q[k];
      end
      o_head_q   <= rsp.heading;
      o_acc_ok_q <= acc_ok_q;
      o_mag_ok_q <= mag_ok_q;
    end
  end

  imuhd_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .fx_i   (field_q[0]),
    .fy_i   (field_q[1]),
    .rsp_o  (rsp)
  );

  assign res_o.valid            = out_valid_q;
  assign res_o.accel_x          = o_acc_q[0];
  assign res_o.accel_y          = o_acc_q[1];
  assign res_o.accel_z          = o_acc_q[2];
  assign res_o.field_x          = o_field_q[0];
  assign res_o.field_y          = o_field_q[1];
  assign res_o.field_z          = o_field_q[2];
  assign res_o.heading_centideg = o_head_q;
  assign res_o.acc_valid        = o_acc_ok_q;
  assign res_o.mag_valid        = o_mag_ok_q;

endmodule

`default_nettype wire
